>>> hw/rtl/assert_macros.svh
// assertion helpers used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every edge outside reset
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication checked at every edge outside reset
`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked outside reset
`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/frcd_pkg.sv
package frcd_pkg;

	localparam int MaxPayload = 32;
	localparam int QueueDepth = 4;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_TAKE    = 2'd1;
	localparam logic [1:0] KIND_ARM     = 2'd2;
	localparam logic [1:0] KIND_ABANDON = 2'd3;

	localparam logic [4:0] V_LENREJ   = 5'd0;
	localparam logic [4:0] V_CRCERR   = 5'd1;
	localparam logic [4:0] V_UNKNOWN  = 5'd2;
	localparam logic [4:0] V_STATE_OK = 5'd3;
	localparam logic [4:0] V_STATE_DUP = 5'd4;
	localparam logic [4:0] V_HB_OK    = 5'd5;
	localparam logic [4:0] V_HB_DUP   = 5'd6;
	localparam logic [4:0] V_EV_QUEUED = 5'd7;
	localparam logic [4:0] V_EV_DUP   = 5'd8;
	localparam logic [4:0] V_EV_FULL  = 5'd9;
	localparam logic [4:0] V_ACK_MATCH = 5'd10;
	localparam logic [4:0] V_ACK_IGN  = 5'd11;
	localparam logic [4:0] V_ARMED    = 5'd12;
	localparam logic [4:0] V_ARM_REF  = 5'd13;
	localparam logic [4:0] V_ABANDONED = 5'd14;
	localparam logic [4:0] V_ABAND_IGN = 5'd15;
	localparam logic [4:0] V_PAYLOAD  = 5'd16;

	localparam logic [7:0] HDR0 = 8'hA5;
	localparam logic [7:0] HDR1 = 8'h5A;
	localparam logic [7:0] T_STATE = 8'h01;
	localparam logic [7:0] T_HB    = 8'h02;
	localparam logic [7:0] T_EVENT = 8'h03;
	localparam logic [7:0] T_ACK   = 8'h04;
	localparam logic [15:0] CRC_INIT = 16'hFFFF;
	localparam logic [15:0] CRC_POLY = 16'hA001;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data_byte;
	} in_item_t;

	typedef struct packed {
		logic [4:0] verdict;
		logic [7:0] frame_kind;
		logic [7:0] seq_number;
		logic [5:0] payload_length;
		logic [7:0] payload_value;
		logic [7:0] lost_frames;
		logic       send_ack;
		logic       last;
	} out_item_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] c, input logic [7:0] b);
		logic [15:0] r;
		r = c ^ {8'h00, b};
		for (int k = 0; k < 8; k++) begin
			r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
		end
		return r;
	endfunction

endpackage

>>> hw/rtl/frcd_if.sv
interface frcd_in_if;
	logic              valid;
	logic              ready;
	frcd_pkg::in_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface frcd_out_if;
	logic               valid;
	logic               ready;
	frcd_pkg::out_item_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

>>> hw/rtl/frame_receiver_crc_dedup_top.sv
// channel   dir   payload
// in_ch     in    kind, data_byte
// out_ch    out   verdict, frame_kind, seq_number, payload_length, payload_value,
//                 lost_frames, send_ack, last
// a byte with no result is taken whenever input is ready; the crc is folded in the same cycle
// a fresh state or queued event frame emits its payload bytes (each a ram read, then a load)
// and the verdict after the last byte; other frames, arm, abandon and rejections give one result
// input is held off until the last result of a transaction has left the output register
// output stalls hold the emitter; reset is asynchronous and clears all control
module frame_receiver_crc_dedup_top #(
	parameter int MAX_PAYLOAD = frcd_pkg::MaxPayload,
	parameter int QUEUE_DEPTH = frcd_pkg::QueueDepth
) (
	input  logic      clk,
	input  logic      arst_n,
	frcd_in_if.sink   in_ch,
	frcd_out_if.source out_ch
);

	localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

	localparam logic [2:0] PH_HUNT0 = 3'd0;
	localparam logic [2:0] PH_HUNT1 = 3'd1;
	localparam logic [2:0] PH_LEN   = 3'd2;
	localparam logic [2:0] PH_TYPE  = 3'd3;
	localparam logic [2:0] PH_SEQ   = 3'd4;
	localparam logic [2:0] PH_PAY   = 3'd5;
	localparam logic [2:0] PH_CRCL  = 3'd6;
	localparam logic [2:0] PH_CRCH  = 3'd7;

	localparam logic [5:0] MAXP = 6'(MAX_PAYLOAD);
	localparam logic [2:0] QDEP = 3'(QUEUE_DEPTH);

	logic [7:0] mem [MAX_PAYLOAD];
	logic [7:0] rd_data;

	logic [2:0]  phase_q;
	logic [5:0]  len_q, idx_q;
	logic [7:0]  type_q, seq_q, crcl_q;
	logic [15:0] crc_q;
	logic        sseed_q, eseed_q, pend_q;
	logic [7:0]  slast_q, elast_q, pseq_q, nseq_q;
	logic [2:0]  qfill_q;

	// emitter: busy while payload bytes or a verdict are owed
	logic                emit_q;
	logic [5:0]          ecnt_q;
	logic                rdv_q;
	frcd_pkg::out_item_t vrd_q;
	logic                obuf_v_q;
	frcd_pkg::out_item_t obuf_q;

	logic [1:0] kind;
	logic [7:0] b;
	logic       acc;
	assign kind = in_ch.data.kind;
	assign b    = in_ch.data.data_byte;
	assign in_ch.ready = !emit_q && !obuf_v_q;
	assign acc  = in_ch.valid && in_ch.ready;

	assign out_ch.valid = obuf_v_q;
	assign out_ch.data  = obuf_q;

	logic [5:0] idx_n;
	assign idx_n = idx_q + 6'd1;

	logic [15:0] crc_in;
	assign crc_in = (phase_q == PH_LEN) ? frcd_pkg::CRC_INIT : crc_q;
	logic [15:0] crc_nx;
	assign crc_nx = frcd_pkg::crc_byte(crc_in, b);

	always_ff @(posedge clk) begin
		if (acc && kind == frcd_pkg::KIND_BYTE && phase_q == PH_PAY && idx_q < MAXP)
			mem[idx_q[AW-1:0]] <= b;
		if (!rdv_q)
			rd_data <= mem[ecnt_q[AW-1:0]];
	end

	// classification of a finished frame
	frcd_pkg::out_item_t cls;
	logic       cls_pay;
	logic       s_upd, e_upd, q_inc, p_clr;
	always_comb begin
		cls = '0;
		cls.frame_kind = type_q;
		cls.seq_number = seq_q;
		cls.payload_length = len_q;
		cls.last = 1'b1;
		cls_pay = 1'b0;
		s_upd = 1'b0; e_upd = 1'b0; q_inc = 1'b0; p_clr = 1'b0;
		priority if (type_q == frcd_pkg::T_STATE || type_q == frcd_pkg::T_HB) begin
			if (!sseed_q || seq_q != slast_q) begin
				s_upd = 1'b1;
				cls.lost_frames = sseed_q ? seq_q - slast_q - 8'd1 : 8'd0;
				cls.verdict = (type_q == frcd_pkg::T_STATE) ? frcd_pkg::V_STATE_OK
					: frcd_pkg::V_HB_OK;
				cls_pay = (type_q == frcd_pkg::T_STATE);
			end else begin
				cls.verdict = (type_q == frcd_pkg::T_STATE) ? frcd_pkg::V_STATE_DUP
					: frcd_pkg::V_HB_DUP;
			end
		end else if (type_q == frcd_pkg::T_EVENT) begin
			priority if (eseed_q && seq_q == elast_q) begin
				cls.verdict = frcd_pkg::V_EV_DUP;
				cls.send_ack = 1'b1;
			end else if (qfill_q >= QDEP) begin
				cls.verdict = frcd_pkg::V_EV_FULL;
			end else begin
				cls.verdict = frcd_pkg::V_EV_QUEUED;
				cls.send_ack = 1'b1;
				cls_pay = 1'b1; e_upd = 1'b1; q_inc = 1'b1;
			end
		end else if (type_q == frcd_pkg::T_ACK) begin
			if (pend_q && seq_q == pseq_q) begin
				cls.verdict = frcd_pkg::V_ACK_MATCH;
				p_clr = 1'b1;
			end else begin
				cls.verdict = frcd_pkg::V_ACK_IGN;
			end
		end else begin
			cls.verdict = frcd_pkg::V_UNKNOWN;
		end
	end

	logic obuf_free;
	assign obuf_free = !obuf_v_q || out_ch.ready;

	// next transaction for the output register
	logic                load_o;
	frcd_pkg::out_item_t o_item;
	always_comb begin
		load_o = 1'b0;
		o_item = '0;
		if (emit_q) begin
			if (rdv_q) begin
				if (obuf_free) begin
					load_o = 1'b1;
					o_item.verdict = frcd_pkg::V_PAYLOAD;
					o_item.frame_kind = vrd_q.frame_kind;
					o_item.seq_number = vrd_q.seq_number;
					o_item.payload_length = vrd_q.payload_length;
					o_item.payload_value = rd_data;
				end
			end else if (!(ecnt_q < len_q && ecnt_q < MAXP) && obuf_free) begin
				load_o = 1'b1;
				o_item = vrd_q;
			end
		end else if (acc) begin
			unique case (kind)
				frcd_pkg::KIND_TAKE: begin
				end
				frcd_pkg::KIND_ARM: begin
					load_o = 1'b1;
					o_item.last = 1'b1;
					if (pend_q) begin
						o_item.verdict = frcd_pkg::V_ARM_REF;
						o_item.seq_number = pseq_q;
					end else begin
						o_item.verdict = frcd_pkg::V_ARMED;
						o_item.seq_number = nseq_q;
					end
				end
				frcd_pkg::KIND_ABANDON: begin
					load_o = 1'b1;
					o_item.last = 1'b1;
					if (pend_q) begin
						o_item.verdict = frcd_pkg::V_ABANDONED;
						o_item.seq_number = pseq_q;
					end else begin
						o_item.verdict = frcd_pkg::V_ABAND_IGN;
					end
				end
				default: begin
					if (phase_q == PH_LEN && b > 8'(MAXP)) begin
						load_o = 1'b1;
						o_item.verdict = frcd_pkg::V_LENREJ;
						o_item.last = 1'b1;
					end else if (phase_q == PH_CRCH && {b, crcl_q} != crc_q) begin
						load_o = 1'b1;
						o_item.verdict = frcd_pkg::V_CRCERR;
						o_item.frame_kind = type_q;
						o_item.seq_number = seq_q;
						o_item.payload_length = len_q;
						o_item.last = 1'b1;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT0;
			len_q <= '0; idx_q <= '0; type_q <= '0; seq_q <= '0; crcl_q <= '0;
			crc_q <= frcd_pkg::CRC_INIT;
			sseed_q <= 1'b0; eseed_q <= 1'b0; pend_q <= 1'b0;
			slast_q <= '0; elast_q <= '0; pseq_q <= '0; nseq_q <= '0;
			qfill_q <= '0;
			emit_q <= 1'b0; ecnt_q <= '0; rdv_q <= 1'b0; vrd_q <= '0;
			obuf_v_q <= 1'b0; obuf_q <= '0;
		end else begin
			if (load_o) begin
				obuf_v_q <= 1'b1;
				obuf_q <= o_item;
			end else if (out_ch.ready) begin
				obuf_v_q <= 1'b0;
			end
			if (emit_q) begin
				// rdv_q: read data for ecnt_q-1 available this cycle
				if (rdv_q) begin
					if (obuf_free) rdv_q <= 1'b0;
				end else if (ecnt_q < len_q && ecnt_q < MAXP) begin
					rdv_q <= 1'b1;
					ecnt_q <= ecnt_q + 6'd1;
				end else if (obuf_free) begin
					emit_q <= 1'b0;
				end
			end else if (acc) begin
				unique case (kind)
					frcd_pkg::KIND_TAKE: begin
						if (qfill_q != 3'd0) qfill_q <= qfill_q - 3'd1;
					end
					frcd_pkg::KIND_ARM: begin
						if (!pend_q) begin
							pend_q <= 1'b1;
							pseq_q <= nseq_q;
							nseq_q <= nseq_q + 8'd1;
						end
					end
					frcd_pkg::KIND_ABANDON: begin
						if (pend_q) pend_q <= 1'b0;
					end
					default: begin
						unique case (phase_q)
							PH_HUNT0: if (b == frcd_pkg::HDR0) phase_q <= PH_HUNT1;
							PH_HUNT1: phase_q <= (b == frcd_pkg::HDR1) ? PH_LEN : PH_HUNT0;
							PH_LEN: begin
								if (b > 8'(MAXP)) begin
									phase_q <= PH_HUNT0;
								end else begin
									len_q <= b[5:0];
									idx_q <= '0;
									crc_q <= crc_nx;
									phase_q <= PH_TYPE;
								end
							end
							PH_TYPE: begin
								type_q <= b; crc_q <= crc_nx; phase_q <= PH_SEQ;
							end
							PH_SEQ: begin
								seq_q <= b; crc_q <= crc_nx;
								phase_q <= (len_q != 6'd0) ? PH_PAY : PH_CRCL;
							end
							PH_PAY: begin
								crc_q <= crc_nx;
								idx_q <= idx_n;
								if (idx_n >= len_q) phase_q <= PH_CRCL;
							end
							PH_CRCL: begin
								crcl_q <= b; phase_q <= PH_CRCH;
							end
							default: begin
								phase_q <= PH_HUNT0;
								if ({b, crcl_q} == crc_q) begin
									emit_q <= 1'b1;
									ecnt_q <= cls_pay ? 6'd0 : MAXP;
									rdv_q <= 1'b0;
									vrd_q <= cls;
									if (s_upd) begin
										sseed_q <= 1'b1; slast_q <= seq_q;
									end
									if (e_upd) begin
										eseed_q <= 1'b1; elast_q <= seq_q;
									end
									if (q_inc) qfill_q <= qfill_q + 3'd1;
									if (p_clr) pend_q <= 1'b0;
								end
							end
						endcase
					end
				endcase
			end
		end
	end

endmodule

>>> hw/rtl/frcd_checker.sv
`include "assert_macros.svh"

module frcd_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_ready,
	input logic               out_valid,
	input logic               out_ready,
	input frcd_pkg::out_item_t out_data
);

	`ASSERT_IMPLIES(a_ack_only_ev, out_valid && out_data.send_ack,
		out_data.verdict == frcd_pkg::V_EV_QUEUED || out_data.verdict == frcd_pkg::V_EV_DUP,
		"send_ack on wrong verdict")
	`ASSERT_IMPLIES(a_pay_not_last, out_valid && out_data.verdict == frcd_pkg::V_PAYLOAD,
		!out_data.last, "payload byte marked last")
	`ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data),
		"stalled transaction changed")
	`ASSERT_IMPLIES(a_no_take_busy, in_valid && out_valid && !out_ready, !in_ready,
		"input taken while result stalled")

endmodule

bind frame_receiver_crc_dedup_top frcd_checker u_frcd_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_ch.valid),
	.in_ready(in_ch.ready),
	.out_valid(out_ch.valid),
	.out_ready(out_ch.ready),
	.out_data(out_ch.data)
);
